>>> rtl/uv_sphere_vertex_generator_core_assert.svh
// assertion macros shared by the vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define UVSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvsg assertion failed");

// next-cycle implication
`define UVSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvsg assertion failed");

`endif

>>> rtl/uvsg_pkg.sv
`timescale 1ns / 1ps
package uvsg_pkg;

    localparam int unsigned MAX_GRID   = 256;
    localparam int unsigned FRAC_BITS  = 15;
    localparam int unsigned DIV_GROUPS = 8;
    localparam int unsigned DIV_STEP   = 4;
    localparam int unsigned PIPE_LAST  = 16;
    localparam int unsigned SIDE_LEN   = 15;
    localparam int unsigned TEX_LEN    = 7;

    localparam logic [8:0]  CNT_RESET = 9'd16;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [30:0] COEF_A    = 31'd1686629713;
    localparam logic [29:0] COEF_B    = 30'd688904866;
    localparam logic [26:0] COEF_C    = 27'd76016977;

    typedef enum logic {
        CFG_RING_COUNT   = 1'b0,
        CFG_SECTOR_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [32:0] q;
        logic [7:0]  rem;
        logic [15:0] q15;
        logic [7:0]  rem15;
        logic [31:0] q31;
        logic [7:0]  rem31;
    } t_div;

    typedef struct packed {
        logic        tri_valid;
        logic [15:0] idx_here;
        logic [15:0] idx_below;
        logic [15:0] idx_below_next;
        logic [15:0] idx_here_next;
    } t_side;

    typedef struct packed {
        logic [15:0] tex_u;
        logic [15:0] tex_v;
    } t_tex;

    function automatic logic [8:0] eff_count(logic [8:0] v);
        logic [8:0] res;
        priority if (v < 9'd2) begin
            res = 9'd2;
        end else if (v > 9'(MAX_GRID)) begin
            res = 9'(MAX_GRID);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic t_div div_init(logic [7:0] num, logic [7:0] dv);
        t_div d;
        d       = '0;
        d.q     = {32'd0, (num == dv)};
        d.rem   = (num == dv) ? 8'd0 : num;
        return d;
    endfunction

    // four restoring steps of the fraction bits
    function automatic t_div div_group(t_div d_in, logic [7:0] dv, int unsigned grp);
        t_div        d;
        logic [8:0]  dbl;
        int unsigned k;
        d = d_in;
        for (int j = 0; j < DIV_STEP; j++) begin
            dbl = {d.rem, 1'b0};
            k   = grp * DIV_STEP + 32'(j) + 1;
            if (dbl >= {1'b0, dv}) begin
                d.rem = 8'(dbl - {1'b0, dv});
                d.q   = {d.q[31:0], 1'b1};
            end else begin
                d.rem = dbl[7:0];
                d.q   = {d.q[31:0], 1'b0};
            end
            if (k == FRAC_BITS) begin
                d.q15   = d.q[15:0];
                d.rem15 = d.rem;
            end
            if (k == 31) begin
                d.q31   = d.q[31:0];
                d.rem31 = d.rem;
            end
        end
        return d;
    endfunction

    function automatic logic round_up(logic [7:0] rem, logic [7:0] dv);
        return (({1'b0, rem} + {2'b0, dv[7:1]}) >= {1'b0, dv});
    endfunction

    function automatic logic [15:0] sat_q15(logic neg, logic [17:0] mag);
        logic [15:0] res;
        if (neg) begin
            res = (mag > 18'h08000) ? 16'h8000 : 16'(18'd0 - mag);
        end else begin
            res = (mag > 18'h07fff) ? 16'h7fff : mag[15:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/uvsg_qsine.sv
`timescale 1ns / 1ps
module uvsg_qsine (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_phase,
    output logic [30:0] o_mag,
    output logic        o_neg
);
    import uvsg_pkg::*;

    logic [30:0] r_x0, r_x1, r_xb, r_xc;
    logic [30:0] r_x2, r_x2b;
    logic [29:0] r_t;
    logic [30:0] r_u;
    logic [30:0] r_mag;
    logic [4:0]  r_neg;

    logic [30:0] n_x0;
    logic [61:0] sq;
    logic [57:0] cp;
    logic [60:0] p3;
    logic [61:0] p4;

    always_comb begin
        n_x0 = i_phase[30] ? (Q30_ONE - {1'b0, i_phase[29:0]}) : {1'b0, i_phase[29:0]};
        sq   = 62'(r_x0) * 62'(r_x0);
        cp   = 58'(COEF_C) * 58'(r_x2);
        p3   = 61'(r_x2b) * 61'(r_t);
        p4   = 62'(r_xc) * 62'(r_u);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x0  <= n_x0;
            r_x2  <= sq[60:30];
            r_x1  <= r_x0;
            r_t   <= COEF_B - {2'b0, cp[57:30]};
            r_x2b <= r_x2;
            r_xb  <= r_x1;
            r_u   <= COEF_A - p3[60:30];
            r_xc  <= r_xb;
            r_mag <= p4[60:30];
            r_neg <= {r_neg[3:0], i_phase[31]};
        end
    end

    assign o_mag = r_mag;
    assign o_neg = r_neg[4];

endmodule

>>> rtl/uv_sphere_vertex_generator_core.sv
// throughput: one beat per cycle while the output is not stalled, through the pipelined divider and sine units
// an output stall freezes the whole pipeline, nothing is lost or repeated
// reset (synchronous, active low) clears all valid bits and sets both counts to 16
`timescale 1ns / 1ps
`include "uv_sphere_vertex_generator_core_assert.svh"
module uv_sphere_vertex_generator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ring_index,
    input  logic [7:0]         i_sector_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_pos_x,
    output logic signed [15:0] o_pos_y,
    output logic signed [15:0] o_pos_z,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic               o_tri_valid,
    output logic [15:0]        o_idx_here,
    output logic [15:0]        o_idx_below,
    output logic [15:0]        o_idx_below_next,
    output logic [15:0]        o_idx_here_next
);
    import uvsg_pkg::*;

    logic [8:0] r_ring_count, r_sector_count;
    logic [8:0] rc, sc;
    logic [7:0] rd, sd;
    logic       en;

    logic [PIPE_LAST:0] r_vld;
    logic [7:0]         r_ring_a, r_sec_a;

    t_div  r_sdiv [DIV_GROUPS];
    t_div  r_rdiv [DIV_GROUPS];
    t_div  n_sdiv [DIV_GROUPS];
    t_div  n_rdiv [DIV_GROUPS];
    t_side r_side [SIDE_LEN];
    t_side n_side;
    t_tex  r_tex  [TEX_LEN];
    t_tex  n_tex;

    logic [16:0] here_row, below_row;
    logic [8:0]  next_sec;
    logic [31:0] r_lon, r_lat, n_lon, n_lat;

    logic [30:0] sin_lat_mag, cos_lat_mag, sin_lon_mag, cos_lon_mag;
    logic        sin_lat_neg, cos_lat_neg, sin_lon_neg, cos_lon_neg;

    logic [61:0] r_px_mag, r_pz_mag;
    logic        r_px_neg, r_pz_neg;
    logic [15:0] r_py, n_py;
    logic [32:0] py_sum;
    logic [62:0] px_sum, pz_sum;

    logic [15:0] r_pos_x, r_pos_y, r_pos_z;
    t_side       r_out_side;
    t_tex        r_out_tex;

    assign rc = eff_count(r_ring_count);
    assign sc = eff_count(r_sector_count);
    assign rd = 8'(rc - 9'd1);
    assign sd = 8'(sc - 9'd1);

    assign en      = !(r_vld[PIPE_LAST] && i_stall);
    assign o_stall = !en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count   <= CNT_RESET;
            r_sector_count <= CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_RING_COUNT:   r_ring_count   <= i_cfg_data;
                CFG_SECTOR_COUNT: r_sector_count <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAST-1:0], i_valid};
        end
    end

    // index arithmetic and long division
    always_comb begin
        here_row  = 17'(r_ring_a) * 17'(sc);
        below_row = here_row + 17'(sc);
        next_sec  = (({1'b0, r_sec_a} + 9'd1) == sc) ? 9'd0 : ({1'b0, r_sec_a} + 9'd1);
        n_side.tri_valid     = (r_ring_a < rd);
        n_side.idx_here      = 16'(here_row + 17'(r_sec_a));
        n_side.idx_here_next = 16'(here_row + 17'(next_sec));
        if (r_ring_a < rd) begin
            n_side.idx_below      = 16'(below_row + 17'(r_sec_a));
            n_side.idx_below_next = 16'(below_row + 17'(next_sec));
        end else begin
            n_side.idx_below      = 16'd0;
            n_side.idx_below_next = 16'd0;
        end

        n_sdiv[0] = div_group(div_init(r_sec_a, sd), sd, 0);
        n_rdiv[0] = div_group(div_init(r_ring_a, rd), rd, 0);
        for (int g = 1; g < DIV_GROUPS; g++) begin
            n_sdiv[g] = div_group(r_sdiv[g-1], sd, 32'(g));
            n_rdiv[g] = div_group(r_rdiv[g-1], rd, 32'(g));
        end

        n_lon = r_sdiv[DIV_GROUPS-1].q[31:0]
              + 32'(round_up(r_sdiv[DIV_GROUPS-1].rem, sd));
        n_lat = r_rdiv[DIV_GROUPS-1].q31
              + 32'(round_up(r_rdiv[DIV_GROUPS-1].rem31, rd));
        n_tex.tex_u = r_sdiv[DIV_GROUPS-1].q15
                    + 16'(round_up(r_sdiv[DIV_GROUPS-1].rem15, sd));
        n_tex.tex_v = r_rdiv[DIV_GROUPS-1].q15
                    + 16'(round_up(r_rdiv[DIV_GROUPS-1].rem15, rd));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ring_a <= (i_ring_index > rd) ? rd : i_ring_index;
            r_sec_a  <= (i_sector_index > sd) ? sd : i_sector_index;
            r_sdiv   <= n_sdiv;
            r_rdiv   <= n_rdiv;
            r_side[0] <= n_side;
            for (int k = 1; k < SIDE_LEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_lon    <= n_lon;
            r_lat    <= n_lat;
            r_tex[0] <= n_tex;
            for (int k = 1; k < TEX_LEN; k++) begin
                r_tex[k] <= r_tex[k-1];
            end
        end
    end

    // sine units
    uvsg_qsine u_sin_lat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_lat),
        .o_mag   (sin_lat_mag),
        .o_neg   (sin_lat_neg)
    );

    uvsg_qsine u_cos_lat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_lat + 32'h4000_0000),
        .o_mag   (cos_lat_mag),
        .o_neg   (cos_lat_neg)
    );

    uvsg_qsine u_sin_lon (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_lon),
        .o_mag   (sin_lon_mag),
        .o_neg   (sin_lon_neg)
    );

    uvsg_qsine u_cos_lon (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_lon + 32'h4000_0000),
        .o_mag   (cos_lon_mag),
        .o_neg   (cos_lon_neg)
    );

    // products and rounding
    always_comb begin
        py_sum = {2'b0, cos_lat_mag} + 33'h0_0000_4000;
        n_py   = sat_q15(!cos_lat_neg, py_sum[32:15]);
        px_sum = {1'b0, r_px_mag} + (63'd1 << 44);
        pz_sum = {1'b0, r_pz_mag} + (63'd1 << 44);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px_mag   <= 62'(cos_lon_mag) * 62'(sin_lat_mag);
            r_px_neg   <= cos_lon_neg ^ sin_lat_neg;
            r_pz_mag   <= 62'(sin_lon_mag) * 62'(sin_lat_mag);
            r_pz_neg   <= sin_lon_neg ^ sin_lat_neg;
            r_py       <= n_py;
            r_pos_x    <= sat_q15(r_px_neg, px_sum[62:45]);
            r_pos_z    <= sat_q15(r_pz_neg, pz_sum[62:45]);
            r_pos_y    <= r_py;
            r_out_side <= r_side[SIDE_LEN-1];
            r_out_tex  <= r_tex[TEX_LEN-1];
        end
    end

    assign o_valid          = r_vld[PIPE_LAST];
    assign o_pos_x          = r_pos_x;
    assign o_pos_y          = r_pos_y;
    assign o_pos_z          = r_pos_z;
    assign o_tex_u          = r_out_tex.tex_u;
    assign o_tex_v          = r_out_tex.tex_v;
    assign o_tri_valid      = r_out_side.tri_valid;
    assign o_idx_here       = r_out_side.idx_here;
    assign o_idx_below      = r_out_side.idx_below;
    assign o_idx_below_next = r_out_side.idx_below_next;
    assign o_idx_here_next  = r_out_side.idx_here_next;

    `UVSG_ASSERT_IMP(a_last_ring_zero, i_clk, i_rst_n, o_valid && !o_tri_valid, o_idx_below == 16'd0 && o_idx_below_next == 16'd0)
    `UVSG_ASSERT_IMP(a_tex_range, i_clk, i_rst_n, o_valid, o_tex_u <= 16'h8000 && o_tex_v <= 16'h8000)
    `UVSG_ASSERT_IMP(a_row_step, i_clk, i_rst_n, o_valid && o_tri_valid, 16'(o_idx_below - o_idx_here) == 16'(o_idx_below_next - o_idx_here_next))
    `UVSG_ASSERT_NEXT(a_beat_moves, i_clk, i_rst_n, r_vld[0] && !o_stall, r_vld[1])

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import uvsg_pkg::*;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic               tri_valid;
        logic [15:0]        idx_here;
        logic [15:0]        idx_below;
        logic [15:0]        idx_below_next;
        logic [15:0]        idx_here_next;
    } t_vertex;

    // expected vertices in order, predicted from the point and current counts
    class vertex_scoreboard;
        t_vertex     pending[$];
        logic [8:0]  rings;
        logic [8:0]  sectors;
        int unsigned errors;
        int unsigned checked;

        function new();
            rings = 9'd16;
            sectors = 9'd16;
            errors = 0;
            checked = 0;
        endfunction

        function logic [63:0] clamp_count(logic [8:0] v);
            logic [63:0] c;
            c = v;
            if (c < 2) c = 2;
            if (c > 256) c = 256;
            return c;
        endfunction

        function logic [63:0] quarter_wave(logic [63:0] x);
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] u;
            x2 = (x * x) >> 30;
            t = 64'd688904866 - ((64'd76016977 * x2) >> 30);
            u = 64'd1686629713 - ((x2 * t) >> 30);
            return (x * u) >> 30;
        endfunction

        function longint sine_q30(logic [31:0] ph);
            logic [63:0] fr;
            logic [63:0] mag;
            fr = {34'd0, ph[29:0]};
            if (ph[30]) mag = quarter_wave(64'h4000_0000 - fr);
            else mag = quarter_wave(fr);
            return ph[31] ? -longint'(mag) : longint'(mag);
        endfunction

        function logic [15:0] scale_q15(longint v, int sh);
            logic [63:0] mag;
            logic        neg;
            neg = v < 0;
            mag = neg ? -v : v;
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            if (neg) begin
                if (mag > 32768) mag = 32768;
                return 16'(-mag);
            end
            if (mag > 32767) mag = 32767;
            return mag[15:0];
        endfunction

        function void note_point(logic [7:0] ri, logic [7:0] si);
            logic [63:0] rc, sc, r, s, rd, sd, ns, lon64, lat64;
            logic [31:0] lon, lat;
            longint      slat;
            t_vertex     e;
            rc = clamp_count(rings);
            sc = clamp_count(sectors);
            r = ri;
            s = si;
            if (r > rc - 1) r = rc - 1;
            if (s > sc - 1) s = sc - 1;
            rd = rc - 1;
            sd = sc - 1;
            lon64 = ((s << 32) + sd / 2) / sd;
            lat64 = ((r << 31) + rd / 2) / rd;
            lon = lon64[31:0];
            lat = lat64[31:0];
            slat = sine_q30(lat);
            e.pos_x = scale_q15(sine_q30(lon + 32'h4000_0000) * slat, 45);
            e.pos_y = scale_q15(-sine_q30(lat + 32'h4000_0000), 15);
            e.pos_z = scale_q15(sine_q30(lon) * slat, 45);
            e.tex_u = 16'(((s << 15) + sd / 2) / sd);
            e.tex_v = 16'(((r << 15) + rd / 2) / rd);
            ns = (s + 1 == sc) ? 0 : s + 1;
            e.idx_here = 16'(r * sc + s);
            e.idx_here_next = 16'(r * sc + ns);
            e.tri_valid = r < rd;
            e.idx_below = e.tri_valid ? 16'((r + 1) * sc + s) : 16'd0;
            e.idx_below_next = e.tri_valid ? 16'((r + 1) * sc + ns) : 16'd0;
            pending = {pending, e};
        endfunction

        function void check_vertex(t_vertex a);
            t_vertex e;
            if (pending.size() == 0) begin
                $display("%0t unexpected beat, actual %p", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e !== a) begin
                $display("%0t mismatch: expected %p actual %p", $time, e, a);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [8:0]         i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_ring_index;
    logic [7:0]         i_sector_index;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_pos_x, o_pos_y, o_pos_z;
    logic [15:0]        o_tex_u, o_tex_v;
    logic               o_tri_valid;
    logic [15:0]        o_idx_here, o_idx_below, o_idx_below_next, o_idx_here_next;

    uv_sphere_vertex_generator_core i_dut (.*);

    vertex_scoreboard sb = new();
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    longint      cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_RING_COUNT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ring_index = '0;
        i_sector_index = '0;
        i_stall = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= (cycles === 'x) ? 1 : cycles + 1;
        if (cycles > 2_000_000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_vertex('{o_pos_x, o_pos_y, o_pos_z, o_tex_u, o_tex_v, o_tri_valid,
                              o_idx_here, o_idx_below, o_idx_below_next, o_idx_here_next});
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // valid stays high after an accepted beat until the next beat or an idle
    task automatic send_point(logic [7:0] r, logic [7:0] s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ring_index <= r;
        i_sector_index <= s;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(r, s);
    endtask

    task automatic write_counts(logic [8:0] rings, logic [8:0] sectors);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_RING_COUNT;
        i_cfg_data <= rings;
        @(posedge i_clk);
        i_cfg_index <= CFG_SECTOR_COUNT;
        i_cfg_data <= sectors;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.rings = rings;
        sb.sectors = sectors;
    endtask

    task automatic random_phase(int n);
        logic [8:0] rc, sc;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                case ($urandom_range(5))
                    0: begin rc = 9'd2; sc = 9'd2; end
                    1: begin rc = 9'd256; sc = 9'd256; end
                    2: begin rc = 9'($urandom); sc = 9'($urandom); end
                    default: begin
                        rc = 9'($urandom_range(2, 40));
                        sc = 9'($urandom_range(2, 40));
                    end
                endcase
                write_counts(rc, sc);
            end
            rc = 9'(sb.clamp_count(sb.rings));
            sc = 9'(sb.clamp_count(sb.sectors));
            // mostly in-range points, some out of range to hit saturation
            if ($urandom_range(9) == 0)
                send_point(8'($urandom), 8'($urandom));
            else
                send_point(8'($urandom_range(rc - 1)), 8'($urandom_range(sc - 1)));
        end
    endtask

    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 60;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_point(8'd0, 8'd0);
        send_point(8'd15, 8'd15);
        send_point(8'd7, 8'd4);
        send_point(8'd8, 8'd12);
        send_point(8'd255, 8'd255);
        write_counts(9'd2, 9'd2);
        send_point(8'd0, 8'd0);
        send_point(8'd1, 8'd1);
        send_point(8'd0, 8'd1);
        write_counts(9'd256, 9'd256);
        send_point(8'd255, 8'd255);
        send_point(8'd254, 8'd255);
        send_point(8'd128, 8'd64);
        send_point(8'd0, 8'd128);
        write_counts(9'd0, 9'd511);
        send_point(8'd1, 8'd200);
        send_point(8'd0, 8'd255);
        write_counts(9'd3, 9'd5);
        send_point(8'd1, 8'd4);
        send_point(8'd2, 8'd2);
        random_phase(600);
        send_idle_pct = 60;
        recv_idle_pct = 11;
        random_phase(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(600);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("checked %0d vertices over several grid sizes incl. extremes and clamping",
                 sb.checked);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/uvsg_pkg.sv
rtl/uvsg_qsine.sv
rtl/uv_sphere_vertex_generator_core.sv
verif/testbench.sv
